@@ rtl/core/eps_pkg.sv @@
// shared types, constants and lookup functions for the eeprom page transfer splitter
package eps_pkg;

  localparam int unsigned MAX_REQUEST_BYTES = 256;
  localparam int unsigned ADDR_W = 18;
  localparam int unsigned LEN_W = 9;
  localparam int unsigned TYPE_W = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [TYPE_W-1:0] MEMORY_TYPE_RESET = 5'd15;
  localparam logic [TYPE_W-1:0] TYPE_LAST_NARROW = 5'd8;
  localparam logic [TYPE_W-1:0] TYPE_BANK_HIGH = 5'd17;
  localparam logic [TYPE_W-1:0] TYPE_BANK_LOW = 5'd18;
  localparam logic [TYPE_W-1:0] TYPE_BANK_QUAD = 5'd19;

  localparam logic [7:0] BASE_DEVICE = 8'hA0;

  localparam logic [1:0] STATUS_SEGMENT = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_NO_PAGE = 2'd2;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] start_addr;
    logic [LEN_W-1:0]  transfer_length;
  } req_t;

  typedef struct packed {
    logic [7:0]       device_addr;
    logic [15:0]      word_addr;
    logic             wide_address;
    logic [LEN_W-1:0] segment_length;
    logic [7:0]       poll_device_addr;
    logic [1:0]       status;
    logic             last;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] start_addr;
    logic [LEN_W-1:0]  length;
    logic [TYPE_W-1:0] type_index;
    logic [LEN_W-1:0]  page_size;
    logic              wide_address;
    logic [7:0]        poll_device_addr;
    logic [1:0]        status;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  function automatic logic [LEN_W-1:0] page_size(input logic [TYPE_W-1:0] t);
    logic [LEN_W-1:0] p;
    unique case (t) inside
      5'd4, 5'd14, 5'd15:  p = 9'd64;
      5'd7, 5'd8:          p = 9'd8;
      5'd9, 5'd10, 5'd11:  p = 9'd16;
      5'd12, 5'd13:        p = 9'd32;
      5'd16, 5'd17, 5'd18: p = 9'd128;
      5'd19:               p = 9'd256;
      default:             p = 9'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] bank_device(input logic [TYPE_W-1:0] t,
                                             input logic [ADDR_W-1:0] a);
    logic [7:0] d;
    d = BASE_DEVICE;
    if (a[17:16] != 2'b00) begin
      if (t == TYPE_BANK_HIGH) begin
        d = BASE_DEVICE + 8'd8;
      end else if (t == TYPE_BANK_LOW) begin
        d = BASE_DEVICE + 8'd2;
      end else if (t == TYPE_BANK_QUAD) begin
        d = BASE_DEVICE + {5'd0, a[17:16], 1'b0};
      end
    end
    return d;
  endfunction

endpackage

@@ rtl/core/eeprom_page_transfer_splitter.sv @@
// top level: splits bulk eeprom requests into page-safe bus segments
// path: a status-only result passes the queue and the output register; a segment
//   passes the queue, the walker's command register and the output register, and
//   later segments follow one per cycle while rsp_ready does not stall the output
// the walker is busy until a request's last segment; a 2-entry queue decouples intake
// reset: synchronous, clears queue, walker and output valid; memory_type returns to 15
module eeprom_page_transfer_splitter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  eps_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output eps_pkg::rsp_t              rsp,
  input  logic                       cfg_we,
  input  logic [eps_pkg::TYPE_W-1:0] cfg_wdata
);

  logic [eps_pkg::TYPE_W-1:0] memory_type;
  eps_pkg::q_stat_t           q_stat;
  eps_pkg::cmd_t              push_cmd;
  eps_pkg::cmd_t              head;
  logic                       push;
  logic                       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_type <= eps_pkg::MEMORY_TYPE_RESET;
    end else if (cfg_we) begin
      memory_type <= cfg_wdata;
    end
  end

  eps_front u_front (
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .memory_type (memory_type),
    .q_stat      (q_stat),
    .push        (push),
    .cmd         (push_cmd)
  );

  eps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  eps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef SYNTH
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != eps_pkg::STATUS_SEGMENT |-> rsp.last)
    else $error("status-only word without last");

  a_segment_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == eps_pkg::STATUS_SEGMENT |->
      rsp.segment_length != '0 &&
      rsp.segment_length <= eps_pkg::LEN_W'(eps_pkg::MAX_REQUEST_BYTES))
    else $error("segment length out of range");

  a_pop_only_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.not_empty && !rsp_valid || pop && rsp_ready)
    else $error("queue popped while output blocked or queue empty");

  a_type_reset: assert property (@(posedge clk)
    $past(rst) |-> memory_type == eps_pkg::MEMORY_TYPE_RESET)
    else $error("memory type not restored by reset");
`endif

endmodule

@@ rtl/core/eps_front.sv @@
// front end: takes request words, saturates length, classifies and queues them
module eps_front (
  input  logic                       req_valid,
  output logic                       req_ready,
  input  eps_pkg::req_t              req,
  input  logic [eps_pkg::TYPE_W-1:0] memory_type,
  input  eps_pkg::q_stat_t           q_stat,
  output logic                       push,
  output eps_pkg::cmd_t              cmd
);

  logic [eps_pkg::LEN_W-1:0] len_sat;
  logic [eps_pkg::LEN_W-1:0] page;

  always_comb begin
    if (req.transfer_length > eps_pkg::LEN_W'(eps_pkg::MAX_REQUEST_BYTES)) begin
      len_sat = eps_pkg::LEN_W'(eps_pkg::MAX_REQUEST_BYTES);
    end else begin
      len_sat = req.transfer_length;
    end
    page = eps_pkg::page_size(memory_type);

    cmd.operation = req.operation;
    cmd.start_addr = req.start_addr;
    cmd.length = len_sat;
    cmd.type_index = memory_type;
    cmd.page_size = page;
    cmd.wide_address = (memory_type > eps_pkg::TYPE_LAST_NARROW);
    cmd.poll_device_addr = (req.operation == eps_pkg::OP_WRITE) ?
                           eps_pkg::bank_device(memory_type, req.start_addr) : 8'd0;
    if (len_sat == '0) begin
      cmd.status = eps_pkg::STATUS_EMPTY;
    end else if (page == '0) begin
      cmd.status = eps_pkg::STATUS_NO_PAGE;
    end else begin
      cmd.status = eps_pkg::STATUS_SEGMENT;
    end
  end

  assign req_ready = !q_stat.full;
  assign push = req_valid && !q_stat.full;

endmodule

@@ rtl/core/eps_queue.sv @@
// short command queue between front and back
module eps_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  eps_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output eps_pkg::cmd_t    head,
  output eps_pkg::q_stat_t q_stat
);

  eps_pkg::cmd_t                entries [eps_pkg::QUEUE_DEPTH];
  logic [eps_pkg::QPTR_W-1:0]   wr_ptr;
  logic [eps_pkg::QPTR_W-1:0]   rd_ptr;
  logic [eps_pkg::QCNT_W-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign q_stat.full = (count == eps_pkg::QCNT_W'(eps_pkg::QUEUE_DEPTH));
  assign q_stat.not_empty = (count != '0);
  assign do_push = push && !q_stat.full;
  assign do_pop = pop && q_stat.not_empty;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/eps_back.sv @@
// back end: walks one request segment by segment into the output register
module eps_back (
  input  logic             clk,
  input  logic             rst,
  input  eps_pkg::cmd_t    head,
  input  eps_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output eps_pkg::rsp_t    rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                     state;
  eps_pkg::cmd_t              cmd;
  logic [eps_pkg::ADDR_W-1:0] cur_addr;
  logic [eps_pkg::LEN_W-1:0]  remaining;
  logic                       slot_free;
  logic                       emit;
  logic [eps_pkg::LEN_W-1:0]  page_mask;
  logic [7:0]                 offset;
  logic [eps_pkg::LEN_W-1:0]  seg_full;
  logic [eps_pkg::LEN_W-1:0]  seg;
  logic                       seg_last;

  assign slot_free = !rsp_valid || rsp_ready;
  assign pop = (state == S_IDLE) && q_stat.not_empty && slot_free;
  assign emit = (pop && (head.status != eps_pkg::STATUS_SEGMENT)) ||
                ((state == S_RUN) && slot_free);

  always_comb begin
    page_mask = cmd.page_size - 1'b1;
    offset = cur_addr[7:0] & page_mask[7:0];
    // writes stop at the next page boundary
    seg_full = (cmd.operation == eps_pkg::OP_WRITE) ?
               (cmd.page_size - {1'b0, offset}) : cmd.page_size;
    seg = (seg_full > remaining) ? remaining : seg_full;
    seg_last = (seg == remaining);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cmd <= head;
            cur_addr <= head.start_addr;
            remaining <= head.length;
            if (head.status != eps_pkg::STATUS_SEGMENT) begin
              rsp <= '{device_addr: 8'd0, word_addr: 16'd0, wide_address: 1'b0,
                       segment_length: '0, poll_device_addr: 8'd0,
                       status: head.status, last: 1'b1};
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (slot_free) begin
            rsp <= '{device_addr: eps_pkg::bank_device(cmd.type_index, cur_addr),
                     word_addr: cur_addr[15:0],
                     wide_address: cmd.wide_address,
                     segment_length: seg,
                     poll_device_addr: cmd.poll_device_addr,
                     status: eps_pkg::STATUS_SEGMENT,
                     last: seg_last};
            cur_addr <= cur_addr + eps_pkg::ADDR_W'(seg);
            remaining <= remaining - seg;
            if (seg_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
